// ===== rtl/cdir_pkg.sv =====
package cdir_pkg;

	localparam int ADDR_W = 29;
	localparam int CORE_W = 3;
	localparam int MODE_W = 2;
	localparam int TS_W   = 48;
	localparam int MASK_W = 8;
	localparam int CC_W   = 4;
	localparam int CORR_W = 2;

	localparam logic [CC_W-1:0] CORE_COUNT_RESET = 4'd8;

	localparam int MAX_CORES_DEF      = 8;
	localparam int BLOCK_BITS_DEF     = 6;
	localparam int SET_BITS_DEF       = 8;
	localparam int WAYS_DEF           = 8;
	localparam int DIR_INDEX_BITS_DEF = 16;

	localparam logic [MODE_W-1:0] MODE_LOAD_MISS  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_STORE_MISS = 2'd1;
	localparam logic [MODE_W-1:0] MODE_STORE_HIT  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_REPLACE    = 2'd3;

	localparam logic [CORR_W-1:0] CORR_NONE       = 2'd0;
	localparam logic [CORR_W-1:0] CORR_MISSED_HIT = 2'd1;
	localparam logic [CORR_W-1:0] CORR_FALSE_HIT  = 2'd2;

	typedef struct packed {
		logic [MASK_W-1:0] sharers;
		logic [TS_W-1:0]   last_time;
	} dir_entry_t;

endpackage

// ===== rtl/coherence_directory_with_lru_l2.sv =====
// Coherence directory with a true-LRU shared L2 tag store. The directory entry and the L2 set
// row are read from synchronous memory in the cycle the input transfer happens. Once the
// output register is free, the result is computed and loaded into it; the directory entry is
// written back for an in-order access from a valid core, and the L2 row only on a replace.
// in_stall is high from the cycle after each transfer until its result is loaded, longer while
// the previous result still waits in a stalled output register. As the write-back lands before
// the next read, back-to-back accesses to the same entry need no forwarding. A finished result
// waits in the output register while the next access is already taken. After reset the block
// sweeps both memories to zero, one entry per cycle, as a counter runs through 2**CLR_W values
// (65536 by default), and holds in_stall high meanwhile; core_count writes are taken during it.
module coherence_directory_with_lru_l2 #(
	parameter int MAX_CORES      = cdir_pkg::MAX_CORES_DEF,
	parameter int BLOCK_BITS     = cdir_pkg::BLOCK_BITS_DEF,
	parameter int SET_BITS       = cdir_pkg::SET_BITS_DEF,
	parameter int WAYS           = cdir_pkg::WAYS_DEF,
	parameter int DIR_INDEX_BITS = cdir_pkg::DIR_INDEX_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [cdir_pkg::CC_W-1:0]     cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [cdir_pkg::ADDR_W-1:0]   address,
	input  logic [cdir_pkg::CORE_W-1:0]   core,
	input  logic [cdir_pkg::MODE_W-1:0]   mode,
	input  logic [cdir_pkg::TS_W-1:0]     timestamp,
	input  logic                          claimed_l2_hit,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          in_order,
	output logic [cdir_pkg::MASK_W-1:0]   invalidate_mask,
	output logic [cdir_pkg::CORR_W-1:0]   l2_correction,
	output logic                          error
);
	import cdir_pkg::*;

	localparam int BLK_W     = ADDR_W - BLOCK_BITS;
	localparam int EXT_W     = ADDR_W + 24;
	localparam int DIR_DEPTH = 1 << DIR_INDEX_BITS;
	localparam int SET_DEPTH = 1 << SET_BITS;
	localparam int SET_AW    = (SET_BITS > 0) ? SET_BITS : 1;
	localparam int CLR_W     = (DIR_INDEX_BITS > SET_BITS) ? DIR_INDEX_BITS : SET_BITS;
	localparam int LINE_W    = BLK_W + 1;
	localparam int ROW_W     = WAYS * LINE_W;
	localparam int DIR_W     = $bits(dir_entry_t);

	logic [CC_W-1:0]  cc_q;
	logic             clearing_q;
	logic [CLR_W-1:0] clr_cnt_q;

	logic              busy_s1;
	logic [BLK_W-1:0]  blk_s1;
	logic [CORE_W-1:0] core_s1;
	logic [MODE_W-1:0] mode_s1;
	logic [TS_W-1:0]   ts_s1;
	logic              claimed_s1;

	logic              out_valid_q;
	logic              in_order_q;
	logic [MASK_W-1:0] inv_q;
	logic [CORR_W-1:0] corr_q;
	logic              error_q;

	logic               accept;
	logic               fire;
	logic [BLK_W-1:0]   in_blk;
	logic [EXT_W-1:0]   in_blk_ext;
	logic [EXT_W-1:0]   blk_ext_s1;
	logic [DIR_INDEX_BITS-1:0] in_dir_idx;
	logic [DIR_INDEX_BITS-1:0] dir_idx_s1;
	logic [SET_AW-1:0]  in_set;
	logic [SET_AW-1:0]  set_s1;

	logic [DIR_W-1:0]   dir_rdata;
	logic               dir_we;
	logic [DIR_INDEX_BITS-1:0] dir_waddr;
	logic [DIR_W-1:0]   dir_wdata;
	logic [ROW_W-1:0]   l2_rdata;
	logic               l2_we;
	logic [SET_AW-1:0]  l2_waddr;
	logic [ROW_W-1:0]   l2_wdata;

	dir_entry_t         entry;
	dir_entry_t         new_entry;
	logic               bad_core;
	logic               fresh;
	logic               is_store;
	logic [MASK_W-1:0]  mine;
	logic [MASK_W-1:0]  scan;
	logic [MASK_W-1:0]  inv;
	logic [WAYS-1:0]    hit;
	logic [WAYS-1:0]    shift;
	logic               real_hit;
	logic [CORR_W-1:0]  corr;
	logic [ROW_W-1:0]   new_row;

	assign accept   = in_valid && !in_stall;
	assign fire     = busy_s1 && (!out_valid_q || !out_stall);
	assign in_stall = busy_s1 || clearing_q;

	assign in_blk     = address[ADDR_W-1:BLOCK_BITS];
	assign in_blk_ext = EXT_W'(in_blk);
	assign blk_ext_s1 = EXT_W'(blk_s1);
	assign in_dir_idx = in_blk_ext[DIR_INDEX_BITS-1:0];
	assign dir_idx_s1 = blk_ext_s1[DIR_INDEX_BITS-1:0];
	assign in_set     = (SET_BITS > 0) ? in_blk_ext[SET_AW-1:0] : '0;
	assign set_s1     = (SET_BITS > 0) ? blk_ext_s1[SET_AW-1:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q       <= CORE_COUNT_RESET;
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
			busy_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cc_q <= cfg_wr_data;
			end
			if (clearing_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == '1) begin
					clearing_q <= 1'b0;
				end
			end
			if (accept) begin
				busy_s1 <= 1'b1;
			end else if (fire) begin
				busy_s1 <= 1'b0;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			blk_s1     <= in_blk;
			core_s1    <= core;
			mode_s1    <= mode;
			ts_s1      <= timestamp;
			claimed_s1 <= claimed_l2_hit;
		end
		if (fire) begin
			in_order_q <= !bad_core && fresh;
			inv_q      <= bad_core ? '0 : inv;
			corr_q     <= bad_core ? CORR_NONE : corr;
			error_q    <= bad_core;
		end
	end

	always_comb begin
		logic [LINE_W-1:0] line;
		logic [LINE_W-1:0] prev;
		logic              seen;
		entry    = dir_entry_t'(dir_rdata);
		bad_core = ({1'b0, core_s1} >= cc_q) || (int'(core_s1) >= MAX_CORES);
		fresh    = entry.last_time <= ts_s1;
		is_store = mode_s1 inside {MODE_STORE_MISS, MODE_STORE_HIT};
		mine     = MASK_W'(1) << core_s1;
		for (int i = 0; i < MASK_W; i++) begin
			scan[i] = (i < int'(cc_q)) && (i < MAX_CORES);
		end
		inv = is_store ? (entry.sharers & scan & ~mine) : '0;

		new_entry.last_time = ts_s1;
		if (is_store) begin
			new_entry.sharers = mine;
		end else if (mode_s1 == MODE_LOAD_MISS) begin
			new_entry.sharers = entry.sharers | mine;
		end else begin
			new_entry.sharers = entry.sharers & ~mine;
		end

		// Each line is {valid, block tag}; way 0 is the most recently used.
		for (int w = 0; w < WAYS; w++) begin
			line   = l2_rdata[w*LINE_W +: LINE_W];
			hit[w] = line[LINE_W-1] && (line[BLK_W-1:0] == blk_s1);
		end
		real_hit = |hit;

		// Ways up to the first hit, or all of them on a miss, move down by one.
		seen = 1'b0;
		shift[0] = 1'b1;
		for (int w = 1; w < WAYS; w++) begin
			seen     = seen | hit[w-1];
			shift[w] = !seen;
		end
		new_row = l2_rdata;
		new_row[LINE_W-1:0] = {1'b1, blk_s1};
		for (int w = 1; w < WAYS; w++) begin
			prev = l2_rdata[(w-1)*LINE_W +: LINE_W];
			if (shift[w]) begin
				new_row[w*LINE_W +: LINE_W] = prev;
			end
		end

		corr = CORR_NONE;
		if (mode_s1 == MODE_LOAD_MISS || mode_s1 == MODE_STORE_MISS) begin
			if (real_hit && !claimed_s1) begin
				corr = CORR_MISSED_HIT;
			end else if (!real_hit && claimed_s1) begin
				corr = CORR_FALSE_HIT;
			end
		end
	end

	assign dir_we    = clearing_q || (fire && !bad_core && fresh);
	assign dir_waddr = clearing_q ? clr_cnt_q[DIR_INDEX_BITS-1:0] : dir_idx_s1;
	assign dir_wdata = clearing_q ? '0 : DIR_W'(new_entry);

	assign l2_we    = clearing_q || (fire && !bad_core && mode_s1 == MODE_REPLACE);
	assign l2_waddr = clearing_q ? ((SET_BITS > 0) ? clr_cnt_q[SET_AW-1:0] : '0) : set_s1;
	assign l2_wdata = clearing_q ? '0 : new_row;

	cdir_ram #(
		.WIDTH(DIR_W),
		.DEPTH(DIR_DEPTH)
	) u_dir_ram (
		.clk  (clk),
		.we   (dir_we),
		.waddr(dir_waddr),
		.wdata(dir_wdata),
		.re   (accept),
		.raddr(in_dir_idx),
		.rdata(dir_rdata)
	);

	cdir_ram #(
		.WIDTH(ROW_W),
		.DEPTH(SET_DEPTH)
	) u_l2_ram (
		.clk  (clk),
		.we   (l2_we),
		.waddr(l2_waddr),
		.wdata(l2_wdata),
		.re   (accept),
		.raddr(in_set),
		.rdata(l2_rdata)
	);

	assign out_valid       = out_valid_q;
	assign in_order        = in_order_q;
	assign invalidate_mask = inv_q;
	assign l2_correction   = corr_q;
	assign error           = error_q;

endmodule

// ===== rtl/cdir_ram.sv =====
module cdir_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/cdir_chk.sv =====
module cdir_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic                        in_order,
	input logic [cdir_pkg::MASK_W-1:0] invalidate_mask,
	input logic [cdir_pkg::CORR_W-1:0] l2_correction,
	input logic                        error
);
	import cdir_pkg::*;

	// An access holds the input side for the cycle of its write-back.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input transfer taken in the write-back cycle");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> !in_order && invalidate_mask == '0
			&& l2_correction == CORR_NONE)
		else $error("rejected access reports a result");

	a_corr_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> l2_correction == CORR_NONE || l2_correction == CORR_MISSED_HIT
			|| l2_correction == CORR_FALSE_HIT)
		else $error("undefined L2 correction code");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(in_order) && $stable(error)
			&& $stable(invalidate_mask) && $stable(l2_correction))
		else $error("stalled result changed");

endmodule

bind coherence_directory_with_lru_l2 cdir_chk u_cdir_chk (.*);
